[rtl/core/vtd_pkg.sv]
// Shared types and constants for the vertex transform / divide unit.
// No dependencies.
package vtd_pkg;

    localparam int unsigned CoefFrac = 12;
    localparam int unsigned CompFrac = 16;
    localparam int unsigned NumRegs  = 6;

    typedef enum logic [2:0] {
        REG_ROW0      = 3'd0,
        REG_ROW1      = 3'd1,
        REG_ROW2      = 3'd2,
        REG_ROW3      = 3'd3,
        REG_TRANSPOSE = 3'd4,
        REG_DIVIDE    = 3'd5
    } reg_idx_t;

    typedef struct packed {
        logic divide_en;
        logic sat;
    } vtd_flags_t;

endpackage

[rtl/core/vertex_transform_divide_unit.sv]
// Top level of the vertex transform / divide unit: APB registers, stream handshake, pipeline.
// Depends on vtd_pkg, vtd_transform, vtd_divider.
// One vertex is accepted per cycle while the output is not stalled; the result passes
// through three transform stages, a COMPONENT_WIDTH+16 stage bit-per-stage divider and
// output alignment. The whole pipeline advances together whenever the output slot is
// free or being taken; a stall holds every stage.
module vertex_transform_divide_unit #(
    parameter int unsigned COMPONENT_WIDTH = 32,
    parameter int unsigned COEF_WIDTH      = 16
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [5:0]   paddr,
    input  logic [63:0]  pwdata,
    output logic [63:0]  prdata,
    output logic         pready,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [127:0] s_tdata,  // in_x, in_y, in_z, in_w
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [127:0] m_tdata,  // out_x, out_y, out_z, out_w
    output logic [1:0]   m_tuser   // w_was_zero, saturated
);
    import vtd_pkg::*;

    localparam int unsigned CW = COMPONENT_WIDTH;
    localparam int unsigned IW = (CW < 32) ? CW : 32;
    localparam int unsigned NW = CW + CompFrac;
    localparam int unsigned DEPTH = 3 + NW + 3;

    logic [63:0] row_reg [4];
    logic        transpose_reg;
    logic        divide_reg;
    logic        wr;
    logic [2:0]  widx;

    assign pready = 1'b1;
    assign wr     = psel & penable & pwrite;
    assign widx   = paddr[5:3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg[0]    <= 64'h0000_0000_0000_1000;
            row_reg[1]    <= 64'h0000_0000_1000_0000;
            row_reg[2]    <= 64'h0000_1000_0000_0000;
            row_reg[3]    <= 64'h1000_0000_0000_0000;
            transpose_reg <= 1'b0;
            divide_reg    <= 1'b0;
        end
        else if (wr)
        begin
            unique case (widx)
                REG_ROW0:      row_reg[0]    <= pwdata;
                REG_ROW1:      row_reg[1]    <= pwdata;
                REG_ROW2:      row_reg[2]    <= pwdata;
                REG_ROW3:      row_reg[3]    <= pwdata;
                REG_TRANSPOSE: transpose_reg <= pwdata[0];
                REG_DIVIDE:    divide_reg    <= pwdata[0];
                default:       ;
            endcase
        end
    end

    always_comb
    begin
        unique case (widx)
            REG_ROW0:      prdata = row_reg[0];
            REG_ROW1:      prdata = row_reg[1];
            REG_ROW2:      prdata = row_reg[2];
            REG_ROW3:      prdata = row_reg[3];
            REG_TRANSPOSE: prdata = {63'd0, transpose_reg};
            REG_DIVIDE:    prdata = {63'd0, divide_reg};
            default:       prdata = '0;
        endcase
    end

    // pipeline control
    logic [DEPTH-1:0] vld_reg;
    logic             advance;
    assign advance  = !m_tvalid || m_tready;
    assign s_tready = advance;
    assign m_tvalid = vld_reg[DEPTH-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (advance)
        begin
            vld_reg <= {vld_reg[DEPTH-2:0], s_tvalid};
        end
    end

    // coefficient selection and input extension
    logic signed [CW-1:0]         v [4];
    logic signed [COEF_WIDTH-1:0] k [4][4];
    for (genvar i = 0; i < 4; i++)
    begin : g_in
        logic signed [IW-1:0] raw;
        assign raw  = s_tdata[32*i +: IW];
        assign v[i] = CW'(raw);
        for (genvar j = 0; j < 4; j++)
        begin : g_k
            assign k[i][j] = transpose_reg ? row_reg[j][16*i +: COEF_WIDTH]
                                           : row_reg[i][16*j +: COEF_WIDTH];
        end
    end

    logic signed [CW-1:0] r [4];
    logic [3:0]           rsat;
    for (genvar i = 0; i < 4; i++)
    begin : g_dot
        vtd_transform #(.CW(CW), .KW(COEF_WIDTH)) u_dot (
            .clk(clk), .advance(advance), .v(v), .k(k[i]), .res(r[i]), .sat(rsat[i])
        );
    end

    // mode travels with the data through the transform
    vtd_flags_t fl_reg [3];
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            fl_reg[0] <= '{divide_en: divide_reg, sat: 1'b0};
            fl_reg[1] <= fl_reg[0];
            fl_reg[2] <= fl_reg[1];
        end
    end

    logic signed [CW-1:0] q [3];
    logic [2:0]           qovf;
    for (genvar i = 0; i < 3; i++)
    begin : g_div
        vtd_divider #(.NW(NW), .DW(CW), .RW(CW)) u_div (
            .clk(clk), .rst_n(rst_n), .advance(advance),
            .num(NW'(r[i]) <<< CompFrac), .den(r[3]), .quo(q[i]), .ovf(qovf[i])
        );
    end

    // delay line for the undivided result
    localparam int unsigned DL = NW + 2;
    logic signed [CW-1:0] d_reg [DL][4];
    logic                 dsat_reg [DL];
    logic                 den_reg [DL];
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            d_reg[0]    <= r;
            dsat_reg[0] <= |rsat;
            den_reg[0]  <= fl_reg[2].divide_en;
            for (int s = 1; s < DL; s++)
            begin
                d_reg[s]    <= d_reg[s-1];
                dsat_reg[s] <= dsat_reg[s-1];
                den_reg[s]  <= den_reg[s-1];
            end
        end
    end

    localparam logic signed [CW-1:0] OneHi  = CW'((64'sd1 <<< (CW-1)) - 1);
    localparam bit                   OneFit = (CompFrac < CW - 1);
    localparam logic signed [CW-1:0] One    = OneFit ? CW'(64'sd1 <<< CompFrac) : OneHi;

    logic signed [CW-1:0] o [4];
    logic                 wz;
    logic                 osat;
    always_comb
    begin
        wz   = den_reg[DL-1] && (d_reg[DL-1][3] == '0);
        osat = dsat_reg[DL-1];
        o    = d_reg[DL-1];
        if (den_reg[DL-1] && !wz)
        begin
            o[0] = q[0];
            o[1] = q[1];
            o[2] = q[2];
            o[3] = One;
            osat = osat | (|qovf) | !OneFit;
        end
    end

    logic [127:0] od_reg;
    logic [1:0]   ou_reg;
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            for (int i = 0; i < 4; i++)
            begin
                od_reg[32*i +: 32] <= 32'(o[i]);
            end
            ou_reg <= {osat, wz};
        end
    end

    assign m_tdata = od_reg;
    assign m_tuser = ou_reg;

`ifndef SYNTH
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("output changed under stall");
    a_wz_only_div: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[0] |-> m_tdata[127:96] == 32'd0)
        else $error("zero-w flag with nonzero w");
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid |-> s_tready)
        else $error("ready low with empty output");
`endif
endmodule

[rtl/core/vtd_divider.sv]
// Pipelined restoring divider, one quotient bit per stage, signed result with saturation.
// Depends on vtd_pkg.
module vtd_divider #(
    parameter int unsigned NW = 48,
    parameter int unsigned DW = 32,
    parameter int unsigned RW = 32
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 advance,
    input  logic signed [NW-1:0] num,
    input  logic signed [DW-1:0] den,
    output logic signed [RW-1:0] quo,
    output logic                 ovf
);
    import vtd_pkg::*;

    localparam int unsigned QW = NW;

    logic [NW-1:0] a_reg [0:NW];
    logic [DW-1:0] b_reg [0:NW];
    logic [NW-1:0] q_reg [0:NW];
    logic [DW:0]   r_reg [0:NW];
    logic          neg_reg [0:NW];
    logic [DW:0]   trial [NW];
    logic [DW+1:0] diff  [NW];
    logic signed [RW-1:0] quo_reg;
    logic          ovf_reg;

    always_comb
    begin
        for (int s = 0; s < NW; s++)
        begin
            trial[s] = {r_reg[s][DW-1:0], a_reg[s][NW-1-s]};
            diff[s]  = {1'b0, trial[s]} - {2'b00, b_reg[s]};
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            a_reg[0]   <= num[NW-1] ? NW'(-num) : NW'(num);
            b_reg[0]   <= den[DW-1] ? DW'(-den) : DW'(den);
            q_reg[0]   <= '0;
            r_reg[0]   <= '0;
            neg_reg[0] <= num[NW-1] ^ den[DW-1];
            for (int s = 0; s < NW; s++)
            begin
                a_reg[s+1]   <= a_reg[s];
                b_reg[s+1]   <= b_reg[s];
                neg_reg[s+1] <= neg_reg[s];
                r_reg[s+1]   <= diff[s][DW+1] ? trial[s] : diff[s][DW:0];
                q_reg[s+1]   <= q_reg[s] | (NW'(!diff[s][DW+1]) << (NW-1-s));
            end
        end
    end

    localparam logic [QW-1:0] Lim = QW'(1) << (RW-1);
    logic [QW-1:0] q;
    assign q = q_reg[NW];

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            if (neg_reg[NW])
            begin
                ovf_reg <= q > Lim;
                quo_reg <= (q > Lim) ? RW'(-Lim) : RW'(-q);
            end
            else
            begin
                ovf_reg <= q > Lim - 1'b1;
                quo_reg <= (q > Lim - 1'b1) ? RW'(Lim - 1'b1) : RW'(q);
            end
        end
    end

    assign quo = quo_reg;
    assign ovf = ovf_reg;

    logic unused_rst;
    assign unused_rst = rst_n;
endmodule

[rtl/core/vtd_transform.sv]
// Four-lane dot product stage: registered products, registered sum, floor and saturation.
// Depends on vtd_pkg.
module vtd_transform #(
    parameter int unsigned CW = 32,
    parameter int unsigned KW = 16
) (
    input  logic                 clk,
    input  logic                 advance,
    input  logic signed [CW-1:0] v [4],
    input  logic signed [KW-1:0] k [4],
    output logic signed [CW-1:0] res,
    output logic                 sat
);
    import vtd_pkg::*;

    localparam int unsigned PW = CW + KW;
    localparam int unsigned SW = PW + 2;

    logic signed [PW-1:0] prod_reg [4];
    logic signed [SW-1:0] sum_reg;
    logic signed [SW-1:0] sum_next;
    logic signed [SW-CoefFrac-1:0] sh;
    logic signed [CW-1:0] res_reg;
    logic                 sat_reg;

    localparam logic signed [SW-CoefFrac-1:0] Hi = (SW-CoefFrac)'((64'sd1 <<< (CW-1)) - 1);
    localparam logic signed [SW-CoefFrac-1:0] Lo = (SW-CoefFrac)'(-(64'sd1 <<< (CW-1)));

    always_comb
    begin
        sum_next = '0;
        for (int i = 0; i < 4; i++)
        begin
            sum_next = sum_next + SW'(prod_reg[i]);
        end
    end

    assign sh = sum_reg[SW-1:CoefFrac];

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            for (int i = 0; i < 4; i++)
            begin
                prod_reg[i] <= PW'(v[i]) * PW'(k[i]);
            end
            sum_reg <= sum_next;
            if (sh > Hi)
            begin
                res_reg <= CW'(Hi);
                sat_reg <= 1'b1;
            end
            else if (sh < Lo)
            begin
                res_reg <= CW'(Lo);
                sat_reg <= 1'b1;
            end
            else
            begin
                res_reg <= CW'(sh);
                sat_reg <= 1'b0;
            end
        end
    end

    assign res = res_reg;
    assign sat = sat_reg;
endmodule

[verif/vtd_checker.sv]
// Scoreboard for the vertex transform / divide unit: tracks register writes,
// predicts each vertex result and compares it with the output stream.
// Depends on vtd_pkg.
module vtd_checker (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [5:0]   paddr,
    input  logic [63:0]  pwdata,
    input  logic         pready,
    input  logic         s_tvalid,
    input  logic         s_tready,
    input  logic [127:0] s_tdata,
    input  logic         m_tvalid,
    input  logic         m_tready,
    input  logic [127:0] m_tdata,
    input  logic [1:0]   m_tuser,
    output int           fail_count,
    output int           pending
);
    import vtd_pkg::*;

    typedef struct {
        logic [127:0] comps;
        logic [1:0]   flags;
    } vertex_result_t;

    logic [63:0]    matrix_rows [4];
    logic           transpose_mode;
    logic           divide_mode;
    vertex_result_t expected_vertices [$];

    function automatic longint clip32(input longint val, inout logic sat);
        longint hi;
        longint lo;
        hi = 64'sd2147483647;
        lo = -64'sd2147483648;
        if (val > hi)
        begin
            sat = 1'b1;
            return hi;
        end
        if (val < lo)
        begin
            sat = 1'b1;
            return lo;
        end
        return val;
    endfunction

    function automatic vertex_result_t transform_vertex(input logic [127:0] d);
        vertex_result_t res;
        longint         v [4];
        longint         r [4];
        longint         acc;
        longint         k;
        logic           sat;
        logic           wz;
        sat = 1'b0;
        wz  = 1'b0;
        for (int i = 0; i < 4; i++)
            v[i] = longint'(signed'(d[32*i +: 32]));
        for (int i = 0; i < 4; i++)
        begin
            acc = 0;
            for (int j = 0; j < 4; j++)
            begin
                if (transpose_mode)
                    k = longint'(signed'(matrix_rows[j][16*i +: 16]));
                else
                    k = longint'(signed'(matrix_rows[i][16*j +: 16]));
                acc += v[j] * k;
            end
            r[i] = clip32(acc >>> CoefFrac, sat);
        end
        if (divide_mode)
        begin
            if (r[3] == 0)
                wz = 1'b1;
            else
            begin
                for (int i = 0; i < 3; i++)
                    r[i] = clip32((r[i] * 65536) / r[3], sat);
                r[3] = clip32(longint'(1) << CompFrac, sat);
            end
        end
        for (int i = 0; i < 4; i++)
            res.comps[32*i +: 32] = r[i][31:0];
        res.flags = {sat, wz};
        return res;
    endfunction

    assign pending = expected_vertices.size();

    always @(posedge clk or negedge rst_n)
    begin
        vertex_result_t exp_v;
        if (!rst_n)
        begin
            matrix_rows[0] = 64'h0000_0000_0000_1000;
            matrix_rows[1] = 64'h0000_0000_1000_0000;
            matrix_rows[2] = 64'h0000_1000_0000_0000;
            matrix_rows[3] = 64'h1000_0000_0000_0000;
            transpose_mode = 1'b0;
            divide_mode    = 1'b0;
            fail_count     = 0;
            expected_vertices.delete();
        end
        else
        begin
            if (psel && penable && pwrite && pready)
            begin
                case (paddr[5:3])
                    REG_ROW0, REG_ROW1, REG_ROW2, REG_ROW3:
                        matrix_rows[paddr[4:3]] = pwdata;
                    REG_TRANSPOSE: transpose_mode = pwdata[0];
                    REG_DIVIDE:    divide_mode    = pwdata[0];
                    default: ;
                endcase
            end
            if (m_tvalid && m_tready)
            begin
                if (expected_vertices.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("unexpected result %h user %b", m_tdata, m_tuser);
                end
                else
                begin
                    exp_v = expected_vertices.pop_front();
                    if (exp_v.comps !== m_tdata || exp_v.flags !== m_tuser)
                    begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display("mismatch: exp %h/%b got %h/%b",
                                     exp_v.comps, exp_v.flags, m_tdata, m_tuser);
                    end
                end
            end
            if (s_tvalid && s_tready)
                expected_vertices.push_back(transform_vertex(s_tdata));
        end
    end

endmodule

[verif/tb_top.sv]
// Testbench top for vertex_transform_divide_unit: clock, reset, APB register
// programming, vertex stimulus with idle/stall phases and the verdict.
// Depends on vtd_pkg, vtd_checker and the unit RTL.
module tb_top;
    import vtd_pkg::*;

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         psel = 1'b0;
    logic         penable = 1'b0;
    logic         pwrite = 1'b0;
    logic [5:0]   paddr = '0;
    logic [63:0]  pwdata = '0;
    logic [63:0]  prdata;
    logic         pready;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [127:0] s_tdata = '0;   // in_x, in_y, in_z, in_w
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [127:0] m_tdata;        // out_x, out_y, out_z, out_w
    logic [1:0]   m_tuser;        // w_was_zero, saturated
    int           fail_count;
    int           pending;
    logic         req_taken = 1'b0;
    int           send_idle_pct = 0;
    int           stall_pct = 0;
    logic         hold_off = 1'b0;
    int           quiet_cycles = 0;

    vertex_transform_divide_unit dut (.*);

    vtd_checker checker_i (.*);

    initial
    begin
        forever #6 clk = ~clk;
    end

    always @(posedge clk)
        req_taken <= s_tvalid && s_tready;

    always @(negedge clk)
        m_tready <= !hold_off && ($urandom_range(99) >= stall_pct);

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !rst_n)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > 20000)
        begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    task automatic reg_write(input reg_idx_t idx, input logic [63:0] val);
        @(negedge clk);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        paddr   <= {idx, 3'b000};
        pwdata  <= val;
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (60) @(negedge clk);
    endtask

    task automatic set_matrix(input logic [63:0] r0, r1, r2, r3, input logic tr, dv);
        reg_write(REG_ROW0, r0);
        reg_write(REG_ROW1, r1);
        reg_write(REG_ROW2, r2);
        reg_write(REG_ROW3, r3);
        reg_write(REG_TRANSPOSE, {63'd0, tr});
        reg_write(REG_DIVIDE, {63'd0, dv});
    endtask

    task automatic send_vertex(input logic [127:0] d);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= d;
        do @(negedge clk); while (!req_taken);
    endtask

    function automatic logic [31:0] rand_comp();
        case ($urandom_range(5))
            0:       return 32'($urandom_range(2)) - 32'd1;
            1:       return $urandom();
            2:       return 32'($signed($urandom_range(2000000)) - 1000000);
            3:       return 32'($signed($urandom_range(200)) - 100) << 16;
            4:       return $urandom_range(1) ? 32'h7fff_ffff : 32'h8000_0000;
            default: return 32'($signed($urandom_range(20000)) - 10000);
        endcase
    endfunction

    function automatic logic [63:0] rand_row();
        logic [63:0] r;
        for (int j = 0; j < 4; j++)
            case ($urandom_range(3))
                0:       r[16*j +: 16] = 16'($urandom());
                1:       r[16*j +: 16] = $urandom_range(1) ? 16'h7fff : 16'h8000;
                2:       r[16*j +: 16] = 16'($signed($urandom_range(8192)) - 4096);
                default: r[16*j +: 16] = 16'h0000;
            endcase
        return r;
    endfunction

    initial
    begin
        logic [127:0] vtx;
        logic [63:0]  id0, id1, id2, id3;
        id0 = 64'h0000_0000_0000_1000;
        id1 = 64'h0000_0000_1000_0000;
        id2 = 64'h0000_1000_0000_0000;
        id3 = 64'h1000_0000_0000_0000;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset matrix: identity pass-through, extremes
        send_vertex({32'h7fff_ffff, 32'h8000_0000, 32'h0000_0000, 32'hffff_ffff});
        send_vertex({32'h8000_0000, 32'h7fff_ffff, 32'h0001_0000, 32'h0000_0001});
        drain();
        // divide on: zero w, unit w, tiny w (quotient clips), negative w
        set_matrix(id0, id1, id2, id3, 1'b0, 1'b1);
        send_vertex({32'h0000_0000, 32'h0003_0000, 32'hfffe_0000, 32'h0001_0000});
        send_vertex({32'h0001_0000, 32'h0003_0000, 32'hfffe_0000, 32'h0001_0000});
        send_vertex({32'h0000_0001, 32'h7fff_ffff, 32'h8000_0000, 32'h0001_0000});
        send_vertex({32'hfffe_0000, 32'h0005_0000, 32'h0007_0000, 32'hffff_0000});
        send_vertex({32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'hffff_ffff});
        drain();
        // full-scale coefficients: sums clip both ways, transpose on
        set_matrix({4{16'h7fff}}, {4{16'h8000}}, 64'h7fff_8000_7fff_8000,
                   64'h0000_0000_0000_1000, 1'b1, 1'b0);
        send_vertex({4{32'h7fff_ffff}});
        send_vertex({4{32'h8000_0000}});
        send_vertex({32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff});
        send_vertex({4{32'hffff_ffff}});
        drain();
        set_matrix({4{16'h7fff}}, {4{16'h8000}}, 64'h7fff_8000_7fff_8000,
                   64'h0000_0000_0000_1000, 1'b0, 1'b1);
        send_vertex({4{32'h7fff_ffff}});
        send_vertex({32'h0000_0000, 32'h0001_0000, 32'h8000_0000, 32'h0100_0000});
        drain();

        for (int ph = 0; ph < 12; ph++)
        begin
            if (ph % 4 == 0)
                set_matrix(id0, id1, id2, id3, ph[0], ph[3]);
            else if (ph % 4 == 1)
                set_matrix({4{16'h7fff}}, {4{16'h8000}}, rand_row(), rand_row(),
                           1'b1, 1'b1);
            else
                set_matrix(rand_row(), rand_row(), rand_row(), rand_row(),
                           ph[1], $urandom_range(1));
            case (ph % 4)
                0:
                begin
                    send_idle_pct = 0;
                    stall_pct = 0;
                end
                1:
                begin
                    send_idle_pct = 80;
                    stall_pct = 0;
                end
                2:
                begin
                    send_idle_pct = 0;
                    stall_pct = 80;
                end
                default:
                begin
                    send_idle_pct = 29;
                    stall_pct = 29;
                end
            endcase
            if (ph == 4)
                fork
                    begin
                        hold_off = 1'b1;
                        repeat (300) @(posedge clk);
                        hold_off = 1'b0;
                    end
                join_none
            for (int n = 0; n < 100; n++)
            begin
                vtx = {rand_comp(), rand_comp(), rand_comp(), rand_comp()};
                if ($urandom_range(9) == 0)
                    vtx[127:96] = '0;
                send_vertex(vtx);
                if (ph == 8 && n == 50)
                begin
                    s_tvalid <= 1'b0;
                    while (pending != 0)
                        @(negedge clk);
                end
            end
            drain();
        end

        if (fail_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
